FILE: hdl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg: shared types and constants of the SD card SPI host sequencer
// Holds beat payloads, action, phase, status and command codes and limits.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  typedef enum logic [2:0] {
    ACT_EXCH     = 3'd0,
    ACT_INIT     = 3'd1,
    ACT_READ     = 3'd2,
    ACT_WRITE    = 3'd3,
    ACT_SHUTDOWN = 3'd4,
    ACT_RSV5     = 3'd5,
    ACT_RSV6     = 3'd6,
    ACT_RSV7     = 3'd7
  } action_t;

  typedef enum logic [5:0] {
    PH_IDLE, PH_WAKE, PH_FRAME, PH_R1, PH_TAIL, PH_TOKEN, PH_RDATA,
    PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP, PH_BUSY, PH_DESEL
  } phase_t;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_NO_IDLE = 4'd1;
  localparam logic [3:0] ST_CMD8_REJ = 4'd2;
  localparam logic [3:0] ST_BAD_ECHO = 4'd3;
  localparam logic [3:0] ST_CMD55_FAIL = 4'd4;
  localparam logic [3:0] ST_ACMD41_TO = 4'd5;
  localparam logic [3:0] ST_OCR_FAIL = 4'd6;
  localparam logic [3:0] ST_R1_ERR = 4'd7;
  localparam logic [3:0] ST_TOKEN_FAIL = 4'd8;
  localparam logic [3:0] ST_WR_REJ = 4'd9;
  localparam logic [3:0] ST_BUSY_TO = 4'd10;

  localparam logic [7:0] CMD_NONE = 8'h00;
  localparam logic [7:0] CMD0 = 8'h40;
  localparam logic [7:0] CMD8 = 8'h48;
  localparam logic [7:0] CMD17 = 8'h51;
  localparam logic [7:0] CMD24 = 8'h58;
  localparam logic [7:0] CMD55 = 8'h77;
  localparam logic [7:0] ACMD41 = 8'h69;
  localparam logic [7:0] CMD58 = 8'h7A;

  localparam logic [2:0] REG_R1_LIMIT = 3'd0;
  localparam logic [2:0] REG_TOKEN_LIMIT = 3'd1;
  localparam logic [2:0] REG_RETRY_LIMIT = 3'd2;
  localparam logic [2:0] REG_WRESP_LIMIT = 3'd3;
  localparam logic [2:0] REG_BUSY_LIMIT = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] card_block;
    logic [8:0]  window_offset;
    logic [9:0]  read_length;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       chip_select_low;
    logic       exchange_request;
    logic [7:0] read_data;
    logic       read_valid;
    logic       want_write_byte;
    logic       done_res;
    logic [3:0] status;
    logic       fast_clock;
  } out_item_t;

  // Classified beat handed from the front to the back.
  typedef struct packed {
    logic        start_init;
    logic        start_read;
    logic        start_write;
    logic        start_shut;
    logic        exch;
    logic        rx_ff;
    logic        rx_fe;
    logic        rx_00;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
    logic [31:0] card_block;
    logic [9:0]  win_start;
    logic [9:0]  win_length;
  } cmd_t;

  typedef struct packed {
    logic [15:0] r1_limit;
    logic [15:0] token_limit;
    logic [15:0] retry_limit;
    logic [15:0] wresp_limit;
    logic [23:0] busy_limit;
  } limits_t;

  function automatic logic [7:0] cmd_crc(input logic [7:0] code);
    logic [7:0] c;
    begin
      case (code)
        CMD0: c = 8'h95;
        CMD8: c = 8'h87;
        CMD55: c = 8'h65;
        ACMD41: c = 8'h77;
        default: c = 8'h01;
      endcase
      return c;
    end
  endfunction

endpackage

FILE: hdl/sdspi_fifo.sv
// ----------------------------------------------------------------------------
// sdspi_fifo: short queue of classified beats
// Two-entry register queue that parts the front from the back.
// ----------------------------------------------------------------------------
module sdspi_fifo #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [Width-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [Width-1:0] rd_data
);
  logic [Width-1:0] mem [2];
  logic             wptr, rptr;
  logic [1:0]       count;
  logic             push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
endmodule

FILE: hdl/sdspi_front.sv
// ----------------------------------------------------------------------------
// sdspi_front: input classifier
// Decodes the action, flags rx patterns and clamps the read window.
// ----------------------------------------------------------------------------
module sdspi_front #(
  parameter int BlockBytes = 512
) (
  input  sdspi_pkg::in_item_t in_item,
  output sdspi_pkg::cmd_t     cmd
);
  localparam int BW = ($clog2(BlockBytes + 1) > 10) ? $clog2(BlockBytes + 1) : 10;
  logic [BW:0] ws, wl, room;

  always_comb begin
    ws = '0;
    wl = '0;
    room = '0;
    cmd = '0;
    cmd.start_init  = (in_item.action == sdspi_pkg::ACT_INIT);
    cmd.start_read  = (in_item.action == sdspi_pkg::ACT_READ);
    cmd.start_write = (in_item.action == sdspi_pkg::ACT_WRITE);
    cmd.start_shut  = (in_item.action == sdspi_pkg::ACT_SHUTDOWN);
    cmd.exch        = (in_item.action == sdspi_pkg::ACT_EXCH);
    cmd.rx_ff = (in_item.rx_byte == 8'hFF);
    cmd.rx_fe = (in_item.rx_byte == 8'hFE);
    cmd.rx_00 = (in_item.rx_byte == 8'h00);
    cmd.rx_byte = in_item.rx_byte;
    cmd.write_byte = in_item.write_byte;
    cmd.card_block = in_item.card_block;
    // clamp the window to the block
    ws = (BW+1)'(in_item.window_offset);
    if (ws > (BW+1)'(BlockBytes)) ws = (BW+1)'(BlockBytes);
    room = (BW+1)'(BlockBytes) - ws;
    wl = (BW+1)'(in_item.read_length);
    if (wl > room) wl = room;
    cmd.win_start = 10'(ws);
    cmd.win_length = 10'(wl);
  end
endmodule

FILE: hdl/sdspi_back.sv
// ----------------------------------------------------------------------------
// sdspi_back: command sequencer
// Runs the phase machine for one beat per cycle while the output is not stalled and registers the result.
// ----------------------------------------------------------------------------
module sdspi_back #(
  parameter int BlockBytes = 512,
  parameter int WakeClockBytes = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sdspi_pkg::limits_t   lim,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  sdspi_pkg::cmd_t      cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sdspi_pkg::out_item_t out_item
);
  localparam int CW = ($clog2(BlockBytes + 3) > $clog2(WakeClockBytes + 1)) ?
                      $clog2(BlockBytes + 3) : $clog2(WakeClockBytes + 1);

  sdspi_pkg::phase_t phase, phase_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [23:0] poll_count, poll_count_next;
  logic [15:0] retry_count, retry_count_next;
  logic [7:0]  cmd_code, cmd_code_next;
  logic [31:0] reply_bytes, reply_bytes_next;
  logic [31:0] saved_address, saved_address_next;
  logic [9:0]  window_start, window_start_next;
  logic [9:0]  window_length, window_length_next;
  logic        clock_fast_flag, clock_fast_flag_next;
  logic        init_op, init_op_next;
  logic [7:0]  after_desel, after_desel_next;
  logic [3:0]  status_reg, status_reg_next;
  sdspi_pkg::out_item_t res;
  logic        take;
  logic [23:0] poll_inc;
  logic [15:0] retry_inc;
  logic [CW-1:0] cnt_inc;
  logic [15:0] r1l, tkl, rtl, wrl;
  logic [23:0] bsl;
  logic [CW-1:0] rel;
  logic        active, r1_hit;
  logic [47:0] frame;
  logic [7:0]  rx;

  assign cmd_ready = !out_valid || out_ready;
  assign take = cmd_valid && cmd_ready;
  assign poll_inc = poll_count + 24'd1;
  assign retry_inc = retry_count + 16'd1;
  assign cnt_inc = byte_count + CW'(1);
  // a zero limit behaves as one
  assign r1l = (lim.r1_limit == 16'd0) ? 16'd1 : lim.r1_limit;
  assign tkl = (lim.token_limit == 16'd0) ? 16'd1 : lim.token_limit;
  assign rtl = (lim.retry_limit == 16'd0) ? 16'd1 : lim.retry_limit;
  assign wrl = (lim.wresp_limit == 16'd0) ? 16'd1 : lim.wresp_limit;
  assign bsl = (lim.busy_limit == 24'd0) ? 24'd1 : lim.busy_limit;
  assign rx = cmd.rx_byte;
  assign rel = byte_count - CW'(window_start);

  // next state
  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    poll_count_next = poll_count;
    retry_count_next = retry_count;
    cmd_code_next = cmd_code;
    reply_bytes_next = reply_bytes;
    saved_address_next = saved_address;
    window_start_next = window_start;
    window_length_next = window_length;
    clock_fast_flag_next = clock_fast_flag;
    init_op_next = init_op;
    after_desel_next = after_desel;
    status_reg_next = status_reg;
    r1_hit = 1'b0;
    if (cmd.start_init) begin
      init_op_next = 1'b1;
      clock_fast_flag_next = 1'b0;
      retry_count_next = 16'd0;
      phase_next = sdspi_pkg::PH_WAKE;
      byte_count_next = '0;
    end else if (cmd.start_read || cmd.start_write) begin
      saved_address_next = cmd.card_block;
      if (cmd.start_read) begin
        window_start_next = cmd.win_start;
        window_length_next = cmd.win_length;
        cmd_code_next = sdspi_pkg::CMD17;
      end else begin
        cmd_code_next = sdspi_pkg::CMD24;
      end
      phase_next = sdspi_pkg::PH_FRAME;
      byte_count_next = '0;
    end else if (cmd.start_shut) begin
      init_op_next = 1'b0;
      cmd_code_next = sdspi_pkg::CMD0;
      phase_next = sdspi_pkg::PH_FRAME;
      byte_count_next = '0;
    end else if (cmd.exch) begin
      case (phase)
        sdspi_pkg::PH_IDLE: ;
        sdspi_pkg::PH_WAKE: begin
          byte_count_next = cnt_inc;
          if (cnt_inc >= CW'(WakeClockBytes)) begin
            cmd_code_next = sdspi_pkg::CMD0;
            phase_next = sdspi_pkg::PH_FRAME;
            byte_count_next = '0;
          end
        end
        sdspi_pkg::PH_FRAME: begin
          byte_count_next = cnt_inc;
          if (cnt_inc >= CW'(6)) begin
            phase_next = sdspi_pkg::PH_R1;
            poll_count_next = 24'd0;
          end
        end
        sdspi_pkg::PH_R1: begin
          poll_count_next = poll_inc;
          r1_hit = !cmd.rx_ff || (poll_inc >= {8'd0, r1l});
          if (r1_hit) begin
            phase_next = sdspi_pkg::PH_DESEL;
            after_desel_next = sdspi_pkg::CMD_NONE;
            case (cmd_code)
              sdspi_pkg::CMD0: begin
                if (init_op && rx == 8'h01) after_desel_next = sdspi_pkg::CMD8;
                else status_reg_next = (rx == 8'h01) ? sdspi_pkg::ST_OK
                                                     : sdspi_pkg::ST_NO_IDLE;
              end
              sdspi_pkg::CMD8, sdspi_pkg::CMD58: begin
                if (rx == ((cmd_code == sdspi_pkg::CMD8) ? 8'h01 : 8'h00)) begin
                  phase_next = sdspi_pkg::PH_TAIL;
                  byte_count_next = '0;
                  reply_bytes_next = 32'd0;
                end else begin
                  status_reg_next = (cmd_code == sdspi_pkg::CMD8) ?
                    sdspi_pkg::ST_CMD8_REJ : sdspi_pkg::ST_OCR_FAIL;
                end
              end
              sdspi_pkg::CMD55: begin
                if (rx == 8'h01) after_desel_next = sdspi_pkg::ACMD41;
                else status_reg_next = sdspi_pkg::ST_CMD55_FAIL;
              end
              sdspi_pkg::ACMD41: begin
                if (cmd.rx_00) after_desel_next = sdspi_pkg::CMD58;
                else begin
                  retry_count_next = retry_inc;
                  if (retry_inc >= rtl) status_reg_next = sdspi_pkg::ST_ACMD41_TO;
                  else after_desel_next = sdspi_pkg::CMD55;
                end
              end
              sdspi_pkg::CMD17: begin
                if (cmd.rx_00) begin
                  phase_next = sdspi_pkg::PH_TOKEN;
                  poll_count_next = 24'd0;
                end else status_reg_next = sdspi_pkg::ST_R1_ERR;
              end
              sdspi_pkg::CMD24: begin
                if (cmd.rx_00) phase_next = sdspi_pkg::PH_WTOKEN;
                else status_reg_next = sdspi_pkg::ST_R1_ERR;
              end
              default: status_reg_next = sdspi_pkg::ST_R1_ERR;
            endcase
          end
        end
        sdspi_pkg::PH_TAIL: begin
          reply_bytes_next = {reply_bytes[23:0], rx};
          byte_count_next = cnt_inc;
          if (cnt_inc >= CW'(4)) begin
            phase_next = sdspi_pkg::PH_DESEL;
            after_desel_next = sdspi_pkg::CMD_NONE;
            if (cmd_code == sdspi_pkg::CMD8) begin
              if (reply_bytes[7:0] == 8'h01 && rx == 8'hAA)
                after_desel_next = sdspi_pkg::CMD55;
              else status_reg_next = sdspi_pkg::ST_BAD_ECHO;
            end else if (reply_bytes[22]) begin
              clock_fast_flag_next = 1'b1;
              status_reg_next = sdspi_pkg::ST_OK;
            end else status_reg_next = sdspi_pkg::ST_OCR_FAIL;
          end
        end
        sdspi_pkg::PH_TOKEN: begin
          poll_count_next = poll_inc;
          if (cmd.rx_fe) begin
            phase_next = sdspi_pkg::PH_RDATA;
            byte_count_next = '0;
          end else if (!cmd.rx_ff || poll_inc >= {8'd0, tkl}) begin
            status_reg_next = sdspi_pkg::ST_TOKEN_FAIL;
            after_desel_next = sdspi_pkg::CMD_NONE;
            phase_next = sdspi_pkg::PH_DESEL;
          end
        end
        sdspi_pkg::PH_RDATA: begin
          byte_count_next = cnt_inc;
          if (cnt_inc >= CW'(BlockBytes + 2)) begin
            status_reg_next = sdspi_pkg::ST_OK;
            after_desel_next = sdspi_pkg::CMD_NONE;
            phase_next = sdspi_pkg::PH_DESEL;
          end
        end
        sdspi_pkg::PH_WTOKEN: begin
          phase_next = sdspi_pkg::PH_WDATA;
          byte_count_next = '0;
        end
        sdspi_pkg::PH_WDATA: begin
          byte_count_next = cnt_inc;
          if (cnt_inc >= CW'(BlockBytes)) begin
            phase_next = sdspi_pkg::PH_WCRC;
            byte_count_next = '0;
          end
        end
        sdspi_pkg::PH_WCRC: begin
          byte_count_next = cnt_inc;
          if (cnt_inc >= CW'(2)) begin
            phase_next = sdspi_pkg::PH_WRESP;
            poll_count_next = 24'd0;
          end
        end
        sdspi_pkg::PH_WRESP: begin
          poll_count_next = poll_inc;
          if (!cmd.rx_ff || poll_inc >= {8'd0, wrl}) begin
            if (rx[4:0] == 5'h05) begin
              phase_next = sdspi_pkg::PH_BUSY;
              poll_count_next = 24'd0;
            end else begin
              status_reg_next = sdspi_pkg::ST_WR_REJ;
              after_desel_next = sdspi_pkg::CMD_NONE;
              phase_next = sdspi_pkg::PH_DESEL;
            end
          end
        end
        sdspi_pkg::PH_BUSY: begin
          if (!cmd.rx_00) begin
            status_reg_next = sdspi_pkg::ST_OK;
            after_desel_next = sdspi_pkg::CMD_NONE;
            phase_next = sdspi_pkg::PH_DESEL;
          end else begin
            poll_count_next = poll_inc;
            if (poll_inc >= bsl) begin
              status_reg_next = sdspi_pkg::ST_BUSY_TO;
              after_desel_next = sdspi_pkg::CMD_NONE;
              phase_next = sdspi_pkg::PH_DESEL;
            end
          end
        end
        sdspi_pkg::PH_DESEL: begin
          if (after_desel != sdspi_pkg::CMD_NONE) begin
            cmd_code_next = after_desel;
            phase_next = sdspi_pkg::PH_FRAME;
            byte_count_next = '0;
          end else phase_next = sdspi_pkg::PH_IDLE;
        end
        default: phase_next = sdspi_pkg::PH_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    active = cmd.start_init || cmd.start_read || cmd.start_write || cmd.start_shut ||
             (cmd.exch && phase != sdspi_pkg::PH_IDLE);
    frame = {cmd_code_next,
             (cmd_code_next == sdspi_pkg::CMD8) ? 32'h000001AA :
             (cmd_code_next == sdspi_pkg::ACMD41) ? 32'h40000000 :
             (cmd_code_next == sdspi_pkg::CMD17 || cmd_code_next == sdspi_pkg::CMD24) ?
               saved_address_next : 32'd0,
             sdspi_pkg::cmd_crc(cmd_code_next)};
    res = '0;
    res.tx_byte = 8'hFF;
    case (phase_next)
      sdspi_pkg::PH_FRAME: begin
        case (byte_count_next[2:0])
          3'd0: res.tx_byte = frame[47:40];
          3'd1: res.tx_byte = frame[39:32];
          3'd2: res.tx_byte = frame[31:24];
          3'd3: res.tx_byte = frame[23:16];
          3'd4: res.tx_byte = frame[15:8];
          default: res.tx_byte = frame[7:0];
        endcase
      end
      sdspi_pkg::PH_WTOKEN: res.tx_byte = 8'hFE;
      sdspi_pkg::PH_WDATA: begin
        res.tx_byte = cmd.write_byte;
        res.want_write_byte = active;
      end
      default: ;
    endcase
    if (!active) res.tx_byte = 8'hFF;
    res.chip_select_low = active && phase_next != sdspi_pkg::PH_IDLE &&
                          phase_next != sdspi_pkg::PH_WAKE &&
                          phase_next != sdspi_pkg::PH_DESEL;
    res.exchange_request = active && phase_next != sdspi_pkg::PH_IDLE;
    if (cmd.exch && phase == sdspi_pkg::PH_RDATA && byte_count >= CW'(window_start) &&
        rel < CW'(window_length)) begin
      res.read_valid = 1'b1;
      res.read_data = rx;
    end
    res.done_res = cmd.exch && phase == sdspi_pkg::PH_DESEL &&
                   after_desel == sdspi_pkg::CMD_NONE;
    res.status = status_reg_next;
    res.fast_clock = clock_fast_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sdspi_pkg::PH_IDLE;
      byte_count <= '0;
      poll_count <= 24'd0;
      retry_count <= 16'd0;
      cmd_code <= sdspi_pkg::CMD_NONE;
      reply_bytes <= 32'd0;
      saved_address <= 32'd0;
      window_start <= 10'd0;
      window_length <= 10'd0;
      clock_fast_flag <= 1'b0;
      init_op <= 1'b0;
      after_desel <= sdspi_pkg::CMD_NONE;
      status_reg <= sdspi_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        byte_count <= byte_count_next;
        poll_count <= poll_count_next;
        retry_count <= retry_count_next;
        cmd_code <= cmd_code_next;
        reply_bytes <= reply_bytes_next;
        saved_address <= saved_address_next;
        window_start <= window_start_next;
        window_length <= window_length_next;
        clock_fast_flag <= clock_fast_flag_next;
        init_op <= init_op_next;
        after_desel <= after_desel_next;
        status_reg <= status_reg_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_item <= res;
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    take && res.done_res |=> phase == sdspi_pkg::PH_IDLE)
    else $error("done without return to idle");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.want_write_byte |-> out_item.chip_select_low)
    else $error("data byte requested with card deselected");
endmodule

FILE: hdl/sd_card_spi_host_sequencer_unit.sv
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer_unit: SD card SPI mode host sequencer
// Runs init, block read, block write and shutdown one byte exchange per beat.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  in       | to block  | in_valid / in_ready   | in_item (action, rx byte, ...)
//  out      | from block| out_valid / out_ready | out_item (tx byte, flags, status)
//  cfg      | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Every input beat gives exactly one result beat. The front classifies a beat
// in its accept cycle and drops it into a two-entry queue; the back takes one
// beat a cycle from the queue while the output is not stalled, steps the phase
// machine and registers the result, so a beat passes the queue entry and then
// the result register. A stall on the output holds the back; the queue keeps
// the front open until its two entries are full. rst (synchronous) returns to
// idle with status 0 and the default limits.
module sd_card_spi_host_sequencer_unit #(
  parameter int BLOCK_BYTES = 512,
  parameter int WAKE_CLOCK_BYTES = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sdspi_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sdspi_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_data
);
  sdspi_pkg::cmd_t    cmd_in, cmd_q;
  sdspi_pkg::limits_t lim;
  logic               q_valid, q_ready;

  // Configuration: always accepted, unknown indexes are dropped.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      lim.r1_limit <= 16'd255;
      lim.token_limit <= 16'd65535;
      lim.retry_limit <= 16'd5000;
      lim.wresp_limit <= 16'd1000;
      lim.busy_limit <= 24'd1000000;
    end else if (cfg_valid) begin
      case (cfg_index)
        sdspi_pkg::REG_R1_LIMIT: lim.r1_limit <= cfg_data[15:0];
        sdspi_pkg::REG_TOKEN_LIMIT: lim.token_limit <= cfg_data[15:0];
        sdspi_pkg::REG_RETRY_LIMIT: lim.retry_limit <= cfg_data[15:0];
        sdspi_pkg::REG_WRESP_LIMIT: lim.wresp_limit <= cfg_data[15:0];
        sdspi_pkg::REG_BUSY_LIMIT: lim.busy_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: classify the beat and clamp the read window.
  sdspi_front #(.BlockBytes(BLOCK_BYTES)) u_front (
    .in_item(in_item),
    .cmd(cmd_in)
  );

  // Queue between front and back.
  sdspi_fifo #(.Width($bits(sdspi_pkg::cmd_t))) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(cmd_in),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(cmd_q)
  );

  // Back: phase machine and result register.
  sdspi_back #(.BlockBytes(BLOCK_BYTES), .WakeClockBytes(WAKE_CLOCK_BYTES)) u_back (
    .clk(clk), .rst(rst), .lim(lim),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(cmd_q),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );
endmodule
